// ----- sv/fha_pkg.sv -----
package fha_pkg;

    localparam int MAX_TAPS  = 64;
    localparam int WIN_DEPTH = MAX_TAPS + 1;
    localparam int PTR_W     = $clog2(WIN_DEPTH);
    localparam int HALF_MAX  = MAX_TAPS / 2;
    localparam int HL_W      = 6;
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = 36;
    localparam int AMP_W     = 17;
    localparam int PHASE_W   = 17;
    localparam int CORDIC_N  = 23;
    localparam int SQRT_N    = 18;
    localparam int CNT_W     = 5;
    localparam int HALF_LENGTH_RESET = 16;
    localparam int PHASE_LIM = 46080;

    // Tap magnitudes round(2^17 / (pi * (2m + 1))), unsigned Q1.16.
    localparam logic [16:0] COEF_TAB [0:HALF_MAX-1] = '{
        17'd41722, 17'd13907, 17'd8344, 17'd5960, 17'd4636, 17'd3793, 17'd3209,
        17'd2781,  17'd2454,  17'd2196, 17'd1987, 17'd1814, 17'd1669, 17'd1545,
        17'd1439,  17'd1346,  17'd1264, 17'd1192, 17'd1128, 17'd1070, 17'd1018,
        17'd970,   17'd927,   17'd888,  17'd851,  17'd818,  17'd787,  17'd759,
        17'd732,   17'd707,   17'd684,  17'd662
    };

    // atan(2^-i) in 1/65536 degree.
    localparam logic [21:0] ATAN_TAB [0:CORDIC_N-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117305,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57,      22'd29,     22'd14,     22'd7,
        22'd4,       22'd2,       22'd1
    };

    typedef enum logic [1:0] {
        T_IDLE,
        T_MAC,
        T_POST
    } top_state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_RUN,
        P_DONE
    } post_state_t;

    typedef struct packed {
        logic            wr;
        logic            start;
        logic [HL_W-1:0] h;
    } mac_ctl_t;

    typedef struct packed {
        logic start;
        logic ack;
    } post_ctl_t;

endpackage

// ----- sv/fha_in_if.sv -----
interface fha_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink (input valid, input sample, input frame_start, output ready);
endinterface

// ----- sv/fha_out_if.sv -----
interface fha_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] amplitude;
    logic [16:0] phase;

    modport source (output valid, output amplitude, output phase, input ready);
    modport sink (input valid, input amplitude, input phase, output ready);
endinterface

// ----- sv/fha_mac.sv -----
module fha_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fha_pkg::mac_ctl_t                     ctl,
    input  logic signed [fha_pkg::SAMPLE_W-1:0]   wr_data,
    output logic                                  done,
    output logic signed [fha_pkg::ACC_W-1:0]      acc,
    output logic signed [fha_pkg::SAMPLE_W-1:0]   x
);

    logic signed [fha_pkg::SAMPLE_W-1:0] mem [0:fha_pkg::WIN_DEPTH-1];

    logic [fha_pkg::PTR_W-1:0]           wptr_reg;
    logic [fha_pkg::PTR_W-1:0]           rptr_reg;
    logic [fha_pkg::PTR_W-1:0]           j_reg;
    logic                                iss_reg;
    logic [fha_pkg::HL_W-1:0]            h_reg;
    logic                                rd_v_reg;
    logic [fha_pkg::PTR_W-1:0]           rd_j_reg;
    logic signed [fha_pkg::SAMPLE_W-1:0] rdata_reg;
    logic signed [fha_pkg::SAMPLE_W-1:0] prev_reg;
    logic signed [fha_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [34:0]                  prod_reg;
    logic                                pv_reg;
    logic                                plast_reg;
    logic signed [fha_pkg::ACC_W-1:0]    acc_reg;
    logic                                done_reg;

    logic [fha_pkg::PTR_W-1:0] h7;
    logic [fha_pkg::PTR_W-1:0] two_h;
    logic [fha_pkg::PTR_W-1:0] m_idx;
    logic                      neg_tap;
    logic signed [17:0]        coef;
    logic signed [16:0]        pair;

    assign h7    = fha_pkg::PTR_W'(h_reg);
    assign two_h = fha_pkg::PTR_W'({h_reg, 1'b0});

    // Taps left of center are negative, taps right of center positive.
    always_comb
    begin
        neg_tap = (rd_j_reg <= h7);
        m_idx   = neg_tap ? (h7 - rd_j_reg) : (rd_j_reg - h7 - 1'b1);
        coef    = neg_tap ? -$signed({1'b0, fha_pkg::COEF_TAB[m_idx[4:0]]})
                          :  $signed({1'b0, fha_pkg::COEF_TAB[m_idx[4:0]]});
        pair    = 17'(rdata_reg) + 17'(prev_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
        if (iss_reg)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            j_reg     <= '0;
            iss_reg   <= 1'b0;
            h_reg     <= '0;
            rd_v_reg  <= 1'b0;
            rd_j_reg  <= '0;
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                wptr_reg <= (wptr_reg == fha_pkg::PTR_W'(fha_pkg::WIN_DEPTH - 1))
                            ? '0 : wptr_reg + 1'b1;
            end
            if (ctl.start)
            begin
                rptr_reg <= wptr_reg;
                j_reg    <= '0;
                iss_reg  <= 1'b1;
                h_reg    <= ctl.h;
            end
            else if (iss_reg)
            begin
                rptr_reg <= (rptr_reg == '0)
                            ? fha_pkg::PTR_W'(fha_pkg::WIN_DEPTH - 1) : rptr_reg - 1'b1;
                j_reg    <= j_reg + 1'b1;
                if (j_reg == two_h)
                begin
                    iss_reg <= 1'b0;
                end
            end
            rd_v_reg  <= iss_reg;
            rd_j_reg  <= j_reg;
            pv_reg    <= rd_v_reg && (rd_j_reg != '0);
            plast_reg <= rd_v_reg && (rd_j_reg == two_h);
            done_reg  <= pv_reg && plast_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prev_reg <= rdata_reg;
            if (rd_j_reg == h7)
            begin
                x_reg <= rdata_reg;
            end
        end
        prod_reg <= pair * coef;
        if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + fha_pkg::ACC_W'(prod_reg);
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign x    = x_reg;

endmodule

// ----- sv/fha_post.sv -----
module fha_post (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fha_pkg::post_ctl_t                    ctl,
    input  logic signed [fha_pkg::SAMPLE_W-1:0]   x,
    input  logic signed [fha_pkg::ACC_W-1:0]      acc,
    output logic                                  valid,
    output logic [fha_pkg::AMP_W-1:0]             amplitude,
    output logic signed [fha_pkg::PHASE_W-1:0]    phase
);

    fha_pkg::post_state_t state_reg, state_next;

    logic [fha_pkg::CNT_W-1:0] cnt_reg;
    logic signed [18:0]        x_reg;
    logic signed [18:0]        xi_reg;
    logic                      zero_reg;
    logic signed [47:0]        cx_reg;
    logic signed [47:0]        cy_reg;
    logic signed [31:0]        z_reg;
    logic [35:0]               sq_reg;
    logic [17:0]               root_reg;
    logic [19:0]               rem_reg;

    logic signed [36:0] acc_rnd;
    logic signed [47:0] x0;
    logic signed [47:0] y0;
    logic signed [47:0] sx;
    logic signed [47:0] sy;
    logic signed [31:0] atan_v;
    logic signed [18:0] m_op;
    logic signed [37:0] m_prod;
    logic [21:0]        rem_sh;
    logic [21:0]        trial;
    logic               ge;
    logic [18:0]        amp_rnd;
    logic signed [31:0] z_rnd;
    logic signed [23:0] p_full;

    always_comb
    begin
        acc_rnd = 37'(acc) + 37'sd65536;
        x0      = 48'(x) <<< 25;
        y0      = 48'(acc) <<< 8;
        sx      = cx_reg >>> cnt_reg;
        sy      = cy_reg >>> cnt_reg;
        atan_v  = (cnt_reg < fha_pkg::CNT_W'(fha_pkg::CORDIC_N))
                  ? $signed({10'b0, fha_pkg::ATAN_TAB[cnt_reg]}) : 32'sd0;
        m_op    = (cnt_reg == '0) ? x_reg : xi_reg;
        m_prod  = m_op * m_op;
        rem_sh  = {rem_reg, sq_reg[35:34]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fha_pkg::P_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = fha_pkg::P_RUN;
                end
            end
            fha_pkg::P_RUN:
            begin
                if (cnt_reg == fha_pkg::CNT_W'(fha_pkg::CORDIC_N - 1))
                begin
                    state_next = fha_pkg::P_DONE;
                end
            end
            fha_pkg::P_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = fha_pkg::P_IDLE;
                end
            end
            default:
            begin
                state_next = fha_pkg::P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fha_pkg::P_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fha_pkg::P_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fha_pkg::P_IDLE && ctl.start)
        begin
            x_reg    <= 19'(x);
            xi_reg   <= acc_rnd[35:17];
            zero_reg <= (x == '0) && (acc == '0);
            sq_reg   <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
            if (x < 0)
            begin
                cx_reg <= -x0;
                cy_reg <= -y0;
                z_reg  <= (acc >= 0) ? 32'sd11796480 : -32'sd11796480;
            end
            else
            begin
                cx_reg <= x0;
                cy_reg <= y0;
                z_reg  <= '0;
            end
        end
        else if (state_reg == fha_pkg::P_RUN)
        begin
            if (!cy_reg[47])
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                z_reg  <= z_reg + atan_v;
            end
            else
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                z_reg  <= z_reg - atan_v;
            end
            // The shared multiplier forms x^2, then adds xi^2; the square
            // root then takes two bits of the sum per cycle.
            if (cnt_reg == '0)
            begin
                sq_reg <= m_prod[35:0];
            end
            else if (cnt_reg == 5'd1)
            begin
                sq_reg <= sq_reg + m_prod[35:0];
            end
            else if (cnt_reg <= fha_pkg::CNT_W'(fha_pkg::SQRT_N + 1))
            begin
                sq_reg   <= sq_reg << 2;
                root_reg <= {root_reg[16:0], ge};
                rem_reg  <= ge ? 20'(rem_sh - trial) : 20'(rem_sh);
            end
        end
    end

    always_comb
    begin
        amp_rnd = {1'b0, root_reg} + ((20'(rem_reg) > 20'(root_reg)) ? 19'd1 : 19'd0);
        z_rnd   = z_reg + 32'sd128;
        p_full  = 24'(z_rnd >>> 8);
        valid   = (state_reg == fha_pkg::P_DONE);
        if (amp_rnd[18:17] != 2'b00)
        begin
            amplitude = '1;
        end
        else
        begin
            amplitude = amp_rnd[16:0];
        end
        if (zero_reg)
        begin
            phase = '0;
        end
        else if (p_full > 24'sd46080)
        begin
            phase = 17'(fha_pkg::PHASE_LIM);
        end
        else if (p_full < -24'sd46080)
        begin
            phase = -17'(fha_pkg::PHASE_LIM);
        end
        else
        begin
            phase = p_full[16:0];
        end
    end

endmodule

// ----- sv/fir_hilbert_amplitude_phase_unit.sv -----
// Streaming FIR Hilbert envelope and phase unit. Each accepted sample is
// written into a 65-entry circular sample memory; once 2*half_length+1
// samples of the current frame are present, one shared multiplier runs the
// 2*half_length tap filter at one tap per cycle, then a 23-step CORDIC and
// an 18-step square root run side by side. A sample that produces no result
// is only written into the memory. The input is not ready while an item is
// being worked on.
// The result register lets the next sample be taken while a finished result
// waits for its transfer. A frame start restarts the fill count so no result
// appears until the window has refilled. half_length of zero acts as one and
// values above 32 act as 32; change it only while the unit is idle.
module fir_hilbert_amplitude_phase_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [5:0]        cfg_wdata,
    fha_in_if.sink            in_ch,
    fha_out_if.source         out_ch
);

    fha_pkg::top_state_t state_reg, state_next;

    logic [fha_pkg::HL_W-1:0]  half_length_reg;
    logic [fha_pkg::PTR_W-1:0] fill_reg;
    logic [fha_pkg::PTR_W-1:0] fill_next;
    logic [fha_pkg::HL_W-1:0]  h_eff;
    logic                      enough;
    logic                      accept;
    logic                      load;

    logic                              out_valid_reg;
    logic [fha_pkg::AMP_W-1:0]         amp_reg;
    logic [fha_pkg::PHASE_W-1:0]       phase_reg;

    fha_pkg::mac_ctl_t                   mac_ctl;
    fha_pkg::post_ctl_t                  post_ctl;
    logic                                mac_done;
    logic signed [fha_pkg::ACC_W-1:0]    mac_acc;
    logic signed [fha_pkg::SAMPLE_W-1:0] mac_x;
    logic                                post_valid;
    logic [fha_pkg::AMP_W-1:0]           post_amp;
    logic signed [fha_pkg::PHASE_W-1:0]  post_phase;

    always_comb
    begin
        if (half_length_reg == '0)
        begin
            h_eff = fha_pkg::HL_W'(1);
        end
        else if (half_length_reg > fha_pkg::HL_W'(fha_pkg::HALF_MAX))
        begin
            h_eff = fha_pkg::HL_W'(fha_pkg::HALF_MAX);
        end
        else
        begin
            h_eff = half_length_reg;
        end
        if (in_ch.frame_start)
        begin
            fill_next = fha_pkg::PTR_W'(1);
        end
        else if (fill_reg < fha_pkg::PTR_W'(fha_pkg::WIN_DEPTH))
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
        enough = (fill_next >= fha_pkg::PTR_W'({h_eff, 1'b0}) + 1'b1);
        accept = in_ch.valid && (state_reg == fha_pkg::T_IDLE);
        load   = post_valid && (!out_valid_reg || out_ch.ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fha_pkg::T_IDLE:
            begin
                if (accept && enough)
                begin
                    state_next = fha_pkg::T_MAC;
                end
            end
            fha_pkg::T_MAC:
            begin
                if (mac_done)
                begin
                    state_next = fha_pkg::T_POST;
                end
            end
            fha_pkg::T_POST:
            begin
                if (load)
                begin
                    state_next = fha_pkg::T_IDLE;
                end
            end
            default:
            begin
                state_next = fha_pkg::T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready    = (state_reg == fha_pkg::T_IDLE);
        mac_ctl.wr     = accept;
        mac_ctl.start  = accept && enough;
        mac_ctl.h      = h_eff;
        post_ctl.start = mac_done;
        post_ctl.ack   = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fha_pkg::T_IDLE;
            half_length_reg <= fha_pkg::HL_W'(fha_pkg::HALF_LENGTH_RESET);
            fill_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                half_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            amp_reg   <= post_amp;
            phase_reg <= post_phase;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.amplitude = amp_reg;
    assign out_ch.phase     = phase_reg;

    fha_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .wr_data (in_ch.sample),
        .done    (mac_done),
        .acc     (mac_acc),
        .x       (mac_x)
    );

    fha_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (post_ctl),
        .x         (mac_x),
        .acc       (mac_acc),
        .valid     (post_valid),
        .amplitude (post_amp),
        .phase     (post_phase)
    );

    a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == fha_pkg::T_MAC)
        else $error("filter finished outside the filter phase");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ch.ready))
        else $error("result register overwritten before transfer");

    a_start_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && enough) |=> state_reg == fha_pkg::T_MAC)
        else $error("full window did not start the filter");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fha_pkg::PTR_W'(fha_pkg::WIN_DEPTH))
        else $error("fill count out of range");

    a_post_only_in_post: assert property (@(posedge clk) disable iff (!rst_n)
        post_valid |-> state_reg == fha_pkg::T_POST)
        else $error("post result outside post phase");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int N_RANDOM   = 1250;
    localparam int SETTLE_CYC = 200;

    typedef struct {
        logic [fha_pkg::AMP_W-1:0]   amplitude;
        logic [fha_pkg::PHASE_W-1:0] phase;
    } envelope_t;

    // Holds the Hilbert envelope state and the queue of expected results.
    class envelope_scoreboard;
        logic signed [fha_pkg::SAMPLE_W-1:0] window [0:fha_pkg::WIN_DEPTH-1];
        int unsigned fill;
        int unsigned half_len;
        envelope_t pending[$];
        int errors;
        int matched;

        function new();
            clear_window();
            half_len = fha_pkg::HALF_LENGTH_RESET;
            errors = 0;
            matched = 0;
        endfunction

        function void clear_window();
            foreach (window[i]) window[i] = '0;
            fill = 0;
        endfunction

        function longint floor_sh(longint v, int s);
            return v >>> s;
        endfunction

        function longint coef_mag(int m);
            longint den;
            den = 64'd1000000 * (2 * m + 1);
            return (64'd41721513600 + den / 2) / den;
        endfunction

        function longint root(longint n);
            longint r, b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b = b >>> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint phase_of(longint x, longint y);
            longint z, nx, ny, p;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < fha_pkg::CORDIC_N; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + floor_sh(y, i);
                    ny = y - floor_sh(x, i);
                    z = z + longint'(fha_pkg::ATAN_TAB[i]);
                end
                else
                begin
                    nx = x - floor_sh(y, i);
                    ny = y + floor_sh(x, i);
                    z = z - longint'(fha_pkg::ATAN_TAB[i]);
                end
                x = nx;
                y = ny;
            end
            p = floor_sh(z + 128, 8);
            if (p > fha_pkg::PHASE_LIM) p = fha_pkg::PHASE_LIM;
            if (p < -fha_pkg::PHASE_LIM) p = -fha_pkg::PHASE_LIM;
            return p;
        endfunction

        function void set_half_length(logic [fha_pkg::HL_W-1:0] v);
            half_len = v;
        endfunction

        function void note_sample(logic [fha_pkg::SAMPLE_W-1:0] s, logic fs);
            int unsigned h;
            longint acc, x, xi, c, sq, amp, ph;
            envelope_t e;
            if (fs) clear_window();
            for (int a = fha_pkg::WIN_DEPTH - 1; a > 0; a--) window[a] = window[a-1];
            window[0] = s;
            if (fill < fha_pkg::WIN_DEPTH) fill++;
            h = half_len;
            if (h < 1) h = 1;
            if (h > fha_pkg::HALF_MAX) h = fha_pkg::HALF_MAX;
            if (fill < 2 * h + 1) return;
            acc = 0;
            for (int k = 1; k <= 2 * h; k++)
            begin
                c = (k <= h) ? -coef_mag(h - k) : coef_mag(k - h - 1);
                acc = acc + c * (longint'(window[k]) + longint'(window[k-1]));
            end
            x = window[h];
            xi = floor_sh(acc + 65536, 17);
            sq = x * x + xi * xi;
            amp = root(sq);
            if (sq - amp * amp > amp) amp++;
            if (amp > 131071) amp = 131071;
            e.amplitude = amp[fha_pkg::AMP_W-1:0];
            ph = phase_of(x * 33554432, acc * 256);
            e.phase = ph[fha_pkg::PHASE_W-1:0];
            pending.push_back(e);
        endfunction

        task check_result(logic [fha_pkg::AMP_W-1:0] amp, logic [fha_pkg::PHASE_W-1:0] ph);
            envelope_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, amp);
                return;
            end
            e = pending.pop_front();
            if (amp !== e.amplitude) report_mismatch("amplitude", e.amplitude, amp);
            else if (ph !== e.phase) report_mismatch("phase", e.phase, ph);
            else matched++;
        endtask

        task report_mismatch(string what, longint exp_v, longint got_v);
            errors++;
            $display("MISMATCH %s: expected %0d got %0d", what, exp_v, got_v);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [5:0] cfg_wdata;
    fha_in_if  in_ch ();
    fha_out_if out_ch ();

    fir_hilbert_amplitude_phase_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    envelope_scoreboard sb;
    int long_hold;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: pattern of short stalls, plus long hold-offs on request.
    initial
    begin
        int phase_cnt;
        out_ch.ready = 0;
        phase_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.amplitude, out_ch.phase);
            phase_cnt++;
            if (long_hold > 0)
            begin
                long_hold--;
                out_ch.ready <= 0;
            end
            else if ((phase_cnt / 64) % 3 == 0)
                out_ch.ready <= 1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_sample(logic [15:0] s, logic fs);
        in_ch.valid <= 1;
        in_ch.sample <= s;
        in_ch.frame_start <= fs;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_sample(s, fs);
    endtask

    task automatic pause_in();
        in_ch.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_half_length(logic [5:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_half_length(v);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        int burst;
        int sent;
        int gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
            begin
                send_sample(rand_sample(), ($urandom_range(0, 99) == 0));
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 0;
    endtask

    initial
    begin
        logic [5:0] settings [0:6];
        sb = new();
        long_hold = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        in_ch.valid = 0;
        in_ch.sample = '0;
        in_ch.frame_start = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset length, extremes, frame restart.
        send_sample(16'h7fff, 1);
        repeat (8) send_sample(16'h0000, 0);
        send_sample(16'h8000, 0);
        repeat (6) send_sample(16'h7fff, 0);
        send_sample(16'h8000, 1);
        repeat (3) send_sample(16'h0000, 0);
        pause_in();
        drain();
        write_half_length(6'd0);
        repeat (4) send_sample(16'h8000, 0);
        send_sample(16'h7fff, 0);
        pause_in();
        drain();

        settings = '{6'd1, 6'd63, 6'd32, 6'd33, 6'd2, 6'd7, 6'd16};
        foreach (settings[i])
        begin
            write_half_length(settings[i]);
            send_sample(rand_sample(), 1);
            if (i == 2)
            begin
                // Block the receiver so the unit fills up and stalls.
                long_hold = 400;
            end
            random_phase(N_RANDOM / 7);
            drain();
        end
        $display("Covered half_length 0,1,2,7,16,32,33,63 with %0d results checked.",
            sb.matched);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
